// ===== src/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared constants, types and helpers for the prize target probability block.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int MAX_TARGET = 8191;
  localparam int DEPTH      = MAX_TARGET + 1;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DATA_W     = 32;
  localparam int RAW_W      = 18;
  localparam int Q_W        = 17;
  localparam int PRIZE_W    = 16;
  localparam int TARGET_W   = 13;
  localparam int OUT_W      = 17;
  localparam int OUT_SHIFT  = 14;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = DATA_W + Q_W;

  localparam logic [DATA_W-1:0]   STORE_ONE    = 32'h4000_0000;
  localparam logic [Q_W-1:0]      PROB_ONE     = 17'h10000;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 13'd5000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_LOAD,
    S_WALK,
    S_DRAIN,
    S_FINAL,
    S_CLEAR
  } state_t;

  // one walk step handed to the update pipeline
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              to_top;
    logic              use_low;
  } issue_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  function automatic logic [ADDR_W-1:0] cap_target(input logic [TARGET_W-1:0] target);
    if (32'(target) > MAX_TARGET) begin
      return ADDR_W'(MAX_TARGET);
    end
    return ADDR_W'(target);
  endfunction

  // negative clamps to zero, above one saturates
  function automatic logic [Q_W-1:0] clamp_prob(input logic signed [RAW_W-1:0] raw);
    if (raw[RAW_W-1]) begin
      return '0;
    end else if (raw[Q_W-1:0] > PROB_ONE) begin
      return PROB_ONE;
    end
    return raw[Q_W-1:0];
  endfunction

endpackage

// ===== src/ptp_store.sv =====
// ----------------------------------------------------------------------------
// ptp_store
// Distribution store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ptp_store (
  input  logic                         clk,
  input  ptp_pkg::mem_wr_t             wr,
  input  logic [ptp_pkg::ADDR_W-1:0]   rd_addr_a,
  input  logic [ptp_pkg::ADDR_W-1:0]   rd_addr_b,
  output logic [ptp_pkg::DATA_W-1:0]   rd_data_a,
  output logic [ptp_pkg::DATA_W-1:0]   rd_data_b
);
  import ptp_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== src/ptp_update.sv =====
// ----------------------------------------------------------------------------
// ptp_update
// Walk pipeline: scales the read entries, writes back, sums the capped entry.
// ----------------------------------------------------------------------------
module ptp_update (
  input  logic                         clk,
  input  logic                         rst,
  input  ptp_pkg::issue_t              issue,
  input  logic [ptp_pkg::Q_W-1:0]      q,
  input  logic                         load_acc,
  input  logic [ptp_pkg::DATA_W-1:0]   rd_data_a,
  input  logic [ptp_pkg::DATA_W-1:0]   rd_data_b,
  output ptp_pkg::mem_wr_t             wr,
  output logic [ptp_pkg::DATA_W-1:0]   acc,
  output logic                         busy
);
  import ptp_pkg::*;

  // stage 1: aligned with the read data
  logic              v1;
  logic [ADDR_W-1:0] p1;
  logic              top1;
  logic              low1;

  // stage 2: products
  logic              v2;
  logic [ADDR_W-1:0] p2;
  logic              top2;
  logic [DATA_W-1:0] d2;
  logic [DATA_W-1:0] mv_a2;
  logic [DATA_W-1:0] mv_b2;

  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;

  assign prod_a = PROD_W'(rd_data_a) * PROD_W'(q);
  assign prod_b = PROD_W'(rd_data_b) * PROD_W'(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p1    <= issue.addr;
    top1  <= issue.to_top;
    low1  <= issue.use_low;
    p2    <= p1;
    top2  <= top1;
    d2    <= rd_data_a;
    mv_a2 <= prod_a[FRAC_W +: DATA_W];
    // mass flowing in from the entry one prize below
    mv_b2 <= low1 ? prod_b[FRAC_W +: DATA_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      acc <= rd_data_a;
    end else if (v2 && top2) begin
      acc <= acc + mv_a2;
    end
  end

  always_comb begin
    wr.en   = v2;
    wr.addr = p2;
    wr.data = d2 - mv_a2 + mv_b2;
  end

  assign busy = v1 | v2;

endmodule

// ===== src/ptp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptp_ctrl
// Sequencer: accepts items, walks the store, emits results, clears the store.
// ----------------------------------------------------------------------------
module ptp_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ptp_pkg::RAW_W-1:0]   visit_probability,
  input  logic [ptp_pkg::PRIZE_W-1:0]        stop_prize,
  input  logic                               last_stop,
  input  logic                               cfg_we,
  input  logic [ptp_pkg::TARGET_W-1:0]       cfg_wdata,
  input  logic [ptp_pkg::DATA_W-1:0]         acc,
  input  logic                               upd_busy,
  output logic                               busy,
  output ptp_pkg::issue_t                    issue,
  output logic [ptp_pkg::Q_W-1:0]            q,
  output logic                               load_acc,
  output logic [ptp_pkg::ADDR_W-1:0]         rd_addr_a,
  output logic [ptp_pkg::ADDR_W-1:0]         rd_addr_b,
  output ptp_pkg::mem_wr_t                   wr,
  output logic                               done,
  output logic [ptp_pkg::OUT_W-1:0]          reach_probability
);
  import ptp_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [TARGET_W-1:0] prize_target;
  logic [ADDR_W-1:0]   top_idx;
  logic [ADDR_W-1:0]   p;
  logic [ADDR_W-1:0]   p_next;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [ADDR_W-1:0]   clr_cnt_next;
  logic [PRIZE_W-1:0]  prize;
  logic                last;
  logic                skip;
  logic                accept;

  assign top_idx = cap_target(prize_target);
  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    p_next       = p;
    clr_cnt_next = clr_cnt;
    load_acc     = 1'b0;
    wr.en        = 1'b0;
    wr.addr      = top_idx;
    wr.data      = acc;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        load_acc = 1'b1;
        p_next   = top_idx - 1'b1;
        state_next = skip ? S_FINAL : S_WALK;
      end
      S_WALK: begin
        if (p == '0) begin
          state_next = S_DRAIN;
        end else begin
          p_next = p - 1'b1;
        end
      end
      S_DRAIN: begin
        if (!upd_busy) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        wr.en = 1'b1;
        if (last) begin
          state_next   = S_CLEAR;
          clr_cnt_next = '0;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_cnt;
        wr.data = (clr_cnt == '0) ? STORE_ONE : '0;
        if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + 1'b1;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    // a new target restarts the route from a cleared store
    if (cfg_we) begin
      state_next   = S_CLEAR;
      clr_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prize_target <= TARGET_RESET;
      clr_cnt      <= '0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        prize_target <= cfg_wdata;
      end
      clr_cnt <= clr_cnt_next;
      done    <= (state == S_FINAL) && last;
    end
  end

  always_ff @(posedge clk) begin
    p <= p_next;
    if (accept) begin
      q     <= clamp_prob(visit_probability);
      prize <= stop_prize;
      last  <= last_stop;
    end
    if (state == S_TOP) begin
      skip <= (prize == '0) || (q == '0) || (top_idx == '0);
    end
    if (state == S_FINAL) begin
      reach_probability <= acc[OUT_SHIFT +: OUT_W];
    end
  end

  always_comb begin
    issue.valid   = (state == S_WALK);
    issue.addr    = p;
    issue.use_low = PRIZE_W'(p) >= prize;
    issue.to_top  = PRIZE_W'(top_idx - p) <= prize;
    rd_addr_a     = (state == S_WALK) ? p : top_idx;
    rd_addr_b     = p - prize[ADDR_W-1:0];
  end

endmodule

// ===== src/prize_target_probability_dp_top.sv =====
// ----------------------------------------------------------------------------
// prize_target_probability_dp_top
// Probability of collecting a prize target over the stops of a route.
// ----------------------------------------------------------------------------
// a stop runs one store read-modify-write per entry below T, the capped
//   target; a stop with zero prize, zero probability or zero target skips
//   the walk
// throughput: one stop at a time, busy stays high while the walk runs
// done is registered from the final state of the last stop of a route;
//   the receiver cannot stall
// reset, a target write and the end of each route run a clear pass over
//   all 8192 store entries, with busy high
module prize_target_probability_dp_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ptp_pkg::RAW_W-1:0]   visit_probability,
  input  logic [ptp_pkg::PRIZE_W-1:0]        stop_prize,
  input  logic                               last_stop,
  input  logic                               cfg_we,
  input  logic [ptp_pkg::TARGET_W-1:0]       cfg_wdata,
  output logic                               done,
  output logic [ptp_pkg::OUT_W-1:0]          reach_probability
);
  import ptp_pkg::*;

  issue_t            issue;
  mem_wr_t           ctrl_wr;
  mem_wr_t           upd_wr;
  mem_wr_t           store_wr;
  logic [Q_W-1:0]    q;
  logic              load_acc;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [DATA_W-1:0] rd_data_a;
  logic [DATA_W-1:0] rd_data_b;
  logic [DATA_W-1:0] acc;
  logic              upd_busy;

  ptp_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .visit_probability (visit_probability),
    .stop_prize        (stop_prize),
    .last_stop         (last_stop),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .acc               (acc),
    .upd_busy          (upd_busy),
    .busy              (busy),
    .issue             (issue),
    .q                 (q),
    .load_acc          (load_acc),
    .rd_addr_a         (rd_addr_a),
    .rd_addr_b         (rd_addr_b),
    .wr                (ctrl_wr),
    .done              (done),
    .reach_probability (reach_probability)
  );

  ptp_update u_update (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .q         (q),
    .load_acc  (load_acc),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr        (upd_wr),
    .acc       (acc),
    .busy      (upd_busy)
  );

  assign store_wr = upd_wr.en ? upd_wr : ctrl_wr;

  ptp_store u_store (
    .clk       (clk),
    .wr        (store_wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // checks that walk write-back never overlaps the sequencer's own writes
  a_wr_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(upd_wr.en && ctrl_wr.en))
    else $error("walk write collides with sequencer write");

  a_wr_in_item: assert property (@(posedge clk) disable iff (rst)
    upd_wr.en |-> busy)
    else $error("walk write-back outside an item");

  // total mass is one, so the result never exceeds one
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (reach_probability <= PROB_ONE))
    else $error("result above one");

  a_single_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cfg_we) |=> busy)
    else $error("accepted item did not raise busy");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives routes of stops into the prize target block under several targets
// and checks each reach probability against a forward distribution walk.
// ----------------------------------------------------------------------------

class reach_scoreboard;
  logic [ptp_pkg::DATA_W-1:0] prize_mass [ptp_pkg::DEPTH];
  int unsigned target;
  logic [ptp_pkg::OUT_W-1:0] reach_due [$];
  int errors;

  function new();
    target = ptp_pkg::TARGET_RESET;
    errors = 0;
    clear_mass();
  endfunction

  function void clear_mass();
    foreach (prize_mass[i]) prize_mass[i] = '0;
    prize_mass[0] = ptp_pkg::STORE_ONE;
  endfunction

  function int unsigned cap();
    return (target > ptp_pkg::MAX_TARGET) ? ptp_pkg::MAX_TARGET : target;
  endfunction

  function void set_target(logic [ptp_pkg::TARGET_W-1:0] value);
    target = value;
    clear_mass();
  endfunction

  function int pending();
    return reach_due.size();
  endfunction

  // called for every accepted item
  function void note_stop(logic signed [ptp_pkg::RAW_W-1:0] raw,
                          logic [ptp_pkg::PRIZE_W-1:0] prize, logic last);
    logic [ptp_pkg::Q_W-1:0] q;
    logic [63:0] prod;
    logic [ptp_pkg::DATA_W-1:0] d;
    logic [ptp_pkg::DATA_W-1:0] moved;
    int unsigned top;
    int unsigned dest;
    top = cap();
    if (raw[ptp_pkg::RAW_W-1]) begin
      q = '0;
    end else if (raw[ptp_pkg::Q_W-1:0] > ptp_pkg::PROB_ONE) begin
      q = ptp_pkg::PROB_ONE;
    end else begin
      q = raw[ptp_pkg::Q_W-1:0];
    end
    // descending walk, the top entry absorbs
    if (prize != 0 && q != 0 && top != 0) begin
      for (int p = int'(top) - 1; p >= 0; p--) begin
        d = prize_mass[p];
        prod = 64'(d) * 64'(q);
        moved = prod[47:16];
        prize_mass[p] = d - moved;
        dest = (top - p <= prize) ? top : p + prize;
        prize_mass[dest] = prize_mass[dest] + moved;
      end
    end
    if (last) begin
      reach_due.push_back(ptp_pkg::OUT_W'(prize_mass[top] >> ptp_pkg::OUT_SHIFT));
      clear_mass();
    end
  endfunction

  function void check_reach(logic [ptp_pkg::OUT_W-1:0] actual);
    logic [ptp_pkg::OUT_W-1:0] want;
    if (reach_due.size() == 0) begin
      errors++;
      $display("%0t: reach_probability expected none actual %0d", $time, actual);
      return;
    end
    want = reach_due.pop_front();
    if (actual !== want) begin
      errors++;
      $display("%0t: reach_probability expected %0d actual %0d", $time, want, actual);
    end
  endfunction
endclass

module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [ptp_pkg::RAW_W-1:0] visit_probability = '0;
  logic [ptp_pkg::PRIZE_W-1:0] stop_prize = '0;
  logic last_stop = 1'b0;
  logic cfg_we = 1'b0;
  logic [ptp_pkg::TARGET_W-1:0] cfg_wdata = '0;
  logic done;
  logic [ptp_pkg::OUT_W-1:0] reach_probability;

  reach_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int random_sent = 0;

  prize_target_probability_dp_top u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .visit_probability(visit_probability),
    .stop_prize(stop_prize),
    .last_stop(last_stop),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .reach_probability(reach_probability)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      sb.check_reach(reach_probability);
    end
  end

  // start stays high after acceptance until a gap or the end of a phase
  task automatic send_stop(input logic signed [ptp_pkg::RAW_W-1:0] prob,
                           input logic [ptp_pkg::PRIZE_W-1:0] prize, input logic last);
    start <= 1'b1;
    visit_probability <= prob;
    stop_prize <= prize;
    last_stop <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_stop(prob, prize, last);
  endtask

  task automatic idle_gap();
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // a stop that ends no route gives no strobe, so let the walk finish too
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (sb.cap() + 16) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_target(input logic [ptp_pkg::TARGET_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_target(value);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [ptp_pkg::RAW_W-1:0] rand_prob();
    case ($urandom_range(0, 9))
      0: return 18'sd65536;
      1: return '0;
      2: return -18'($urandom_range(1, 65536));
      3: return 18'($urandom_range(65537, 131071));
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [ptp_pkg::PRIZE_W-1:0] rand_prize(input int unsigned top);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'($urandom_range(0, 65535));
      2: return 16'(top + $urandom_range(0, 3));
      default: return 16'($urandom_range(1, (top > 1) ? top : 1));
    endcase
  endfunction

  initial begin
    #600_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int routes;
    int len;
    bit wide;
    logic [ptp_pkg::TARGET_W-1:0] tgt;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset target, two stops that reach it exactly
    wait_idle();
    send_stop(18'sd32768, 16'd3000, 1'b0);
    idle_gap();
    send_stop(18'sd65536, 16'd2000, 1'b1);

    // largest target, full prize, negative and saturated probabilities
    wait_idle();
    write_target(13'd8191);
    send_stop(18'sd65536, 16'hFFFF, 1'b0);
    send_stop(-18'sd65536, 16'd8191, 1'b0);
    idle_gap();
    send_stop(18'sd131071, 16'd1, 1'b1);
    // route left open, the next target write restarts it
    send_stop(18'sd20000, 16'd4096, 1'b0);

    wait_idle();
    write_target(13'd0);
    send_stop(18'sd65536, 16'hFFFF, 1'b1);
    send_stop(-18'sd1, 16'd0, 1'b1);

    wait_idle();
    write_target(13'd3);
    send_stop(18'sd65536, 16'd0, 1'b0);
    send_stop(18'sd0, 16'd2, 1'b0);
    send_stop(18'sd43690, 16'd1, 1'b0);
    idle_gap();
    send_stop(18'sd65535, 16'd2, 1'b0);
    send_stop(18'sd30000, 16'd5, 1'b1);
    send_stop(18'sd65536, 16'd3, 1'b1);
    send_stop(-18'sd32768, 16'd1, 1'b1);

    wait_idle();
    write_target(13'd12);
    send_stop(18'sd21845, 16'hAAAA, 1'b0);
    send_stop(18'sd52428, 16'd1, 1'b0);
    send_stop(18'sd65536, 16'd11, 1'b0);
    send_stop(18'sd12345, 16'h5555, 1'b1);

    // random phases, mostly small targets
    while (random_sent < 80) begin
      wide = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 9))
        0: tgt = '0;
        default: tgt = 13'($urandom_range(1, 64));
      endcase
      if (wide) tgt = 13'($urandom_range(500, 8191));
      wait_idle();
      write_target(tgt);
      routes = wide ? 1 : $urandom_range(1, 3);
      for (int r = 0; r < routes; r++) begin
        len = wide ? $urandom_range(1, 2) : $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          send_stop(rand_prob(), rand_prize(sb.cap()), k == len - 1);
          random_sent++;
          gaps_on = (random_sent < 56);
          idle_gap();
        end
      end
      // now and then a route cut short by the next target write
      if ($urandom_range(0, 5) == 0) begin
        send_stop(rand_prob(), rand_prize(sb.cap()), 1'b0);
        random_sent++;
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (sb.cap() + 32) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
